@@ hdl/unsigned_to_radix_digits_unit_macros.svh @@
// assertion macros shared by the radix conversion unit
`ifndef UNSIGNED_TO_RADIX_DIGITS_UNIT_MACROS_SVH
`define UNSIGNED_TO_RADIX_DIGITS_UNIT_MACROS_SVH

// condition in a cycle implies a condition in the same cycle
`define UTRD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("utrd check failed");

// condition in a cycle implies a condition in the next cycle
`define UTRD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("utrd check failed");

`endif

@@ hdl/utrd_pkg.sv @@
// types, constants and the digit glyph function of the radix conversion unit
`timescale 1ns / 1ps

package utrd_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_WIDTH_DEF   = 64;

    localparam int RADIX_W = 6;
    localparam int WIDTH_W = 7;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 6;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'h37; // 'A' minus ten
    localparam logic [CHAR_W-1:0] CHAR_NONE   = 7'h00;

    typedef struct packed {
        logic load;        // take a new request
        logic div_start;   // clear remainder and bit counter
        logic div_step;    // one restoring division step
        logic write_digit; // store remainder as next digit
        logic pad_init;    // work out padding count
        logic out_pad;     // emit one padding character
        logic rd_issue;    // read the next digit from the store
        logic out_digit;   // emit the digit just read
        logic out_err;     // emit the bad radix result
    } utrd_cmd_t;

    typedef struct packed {
        logic radix_bad;
        logic val_zero;
        logic div_done;
        logic pad_zero;
        logic idx_zero;
        logic out_free;
    } utrd_stat_t;

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        if (d < DIGIT_W'(10)) begin
            return CHAR_ZERO + dx;
        end
        return CHAR_LETTER + dx;
    endfunction

endpackage

@@ hdl/utrd_ram.sv @@
// generic single port write, registered read RAM
`timescale 1ns / 1ps

module utrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/utrd_ctrl.sv @@
// sequencing state machine of the radix conversion unit
`timescale 1ns / 1ps

module utrd_ctrl
    import utrd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  utrd_stat_t stat,
    output utrd_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_PAD   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_RDATA = 3'd6;
    localparam logic [2:0] S_ERR   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                if (stat.radix_bad) begin
                    state_next = S_ERR;
                end else if (stat.val_zero) begin
                    state_next = S_PAD;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.write_digit = 1'b1;
                // quotient already sits in the value register
                if (stat.val_zero) begin
                    state_next = S_PAD;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_PAD: begin
                cmd.pad_init = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT: begin
                if (!stat.pad_zero) begin
                    cmd.out_pad = stat.out_free;
                end else if (!stat.idx_zero) begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_RDATA;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_RDATA: begin
                if (stat.out_free) begin
                    cmd.out_digit = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_ERR: begin
                if (stat.out_free) begin
                    cmd.out_err = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/utrd_datapath.sv @@
// divider, digit store, counters and output register of the radix conversion unit
`timescale 1ns / 1ps

module utrd_datapath
    import utrd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  utrd_cmd_t              cmd,
    output utrd_stat_t             stat,
    input  logic [VALUE_WIDTH-1:0] s_value,
    input  logic [RADIX_W-1:0]     s_radix,
    input  logic [WIDTH_W-1:0]     s_min_width,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [CHAR_W-1:0]      m_character,
    output logic                   m_last,
    output logic                   m_error
);

`include "unsigned_to_radix_digits_unit_macros.svh"

    localparam int AW = $clog2(VALUE_WIDTH);
    localparam int CW = $clog2(VALUE_WIDTH + 1);
    localparam int BW = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] val_reg;
    logic [RADIX_W-1:0]     radix_reg;
    logic [WIDTH_W-1:0]     width_reg;
    logic [DIGIT_W-1:0]     rem_reg;
    logic [BW-1:0]          bit_reg;
    logic [CW-1:0]          count_reg;
    logic [WIDTH_W-1:0]     pad_reg;
    logic [CW-1:0]          idx_reg;
    logic                   m_valid_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic                   last_reg;
    logic                   error_reg;

    logic [DIGIT_W:0]       shifted;
    logic [DIGIT_W:0]       diff;
    logic                   fits;
    logic [DIGIT_W-1:0]     rem_next;
    logic [VALUE_WIDTH-1:0] val_next;
    logic [WIDTH_W-1:0]     count_ext;
    logic [WIDTH_W-1:0]     pad_next;
    logic [CW-1:0]          idx_dec;
    logic [DIGIT_W-1:0]     rd_data;
    logic [WIDTH_W-1:0]     width_next;

    // restoring division, one quotient bit a cycle
    assign shifted  = {rem_reg, val_reg[VALUE_WIDTH-1]};
    assign diff     = shifted - {1'b0, radix_reg};
    assign fits     = shifted >= {1'b0, radix_reg};
    assign rem_next = fits ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
    assign val_next = {val_reg[VALUE_WIDTH-2:0], fits};

    assign width_next = (s_min_width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH)
                                                            : s_min_width;
    assign count_ext  = WIDTH_W'(count_reg);
    assign pad_next   = (width_reg > count_ext) ? width_reg - count_ext : '0;
    assign idx_dec    = idx_reg - CW'(1);

    utrd_ram #(
        .WIDTH(DIGIT_W),
        .DEPTH(VALUE_WIDTH)
    ) u_store (
        .clk  (aclk),
        .we   (cmd.write_digit),
        .waddr(count_reg[AW-1:0]),
        .wdata(rem_reg),
        .re   (cmd.rd_issue),
        .raddr(idx_dec[AW-1:0]),
        .rdata(rd_data)
    );

    assign stat.radix_bad = (radix_reg < RADIX_MIN) || (radix_reg > RADIX_MAX);
    assign stat.val_zero  = (val_reg == '0);
    assign stat.div_done  = (bit_reg == BW'(VALUE_WIDTH - 1));
    assign stat.pad_zero  = (pad_reg == '0);
    assign stat.idx_zero  = (idx_reg == '0);
    assign stat.out_free  = !m_valid_reg || m_ready;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            pad_reg     <= '0;
            idx_reg     <= '0;
            bit_reg     <= '0;
        end else begin
            if (cmd.out_pad || cmd.out_digit || cmd.out_err) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.load) begin
                count_reg <= '0;
            end else if (cmd.write_digit) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.pad_init) begin
                pad_reg <= pad_next;
                idx_reg <= count_reg;
            end else begin
                if (cmd.out_pad) begin
                    pad_reg <= pad_reg - WIDTH_W'(1);
                end
                if (cmd.out_digit) begin
                    idx_reg <= idx_dec;
                end
            end
            if (cmd.div_start) begin
                bit_reg <= '0;
            end else if (cmd.div_step) begin
                bit_reg <= bit_reg + BW'(1);
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            val_reg   <= s_value;
            radix_reg <= s_radix;
            width_reg <= width_next;
        end else if (cmd.div_step) begin
            val_reg <= val_next;
        end
        if (cmd.div_start) begin
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
        end
        if (cmd.out_pad) begin
            char_reg  <= CHAR_ZERO;
            last_reg  <= (pad_reg == WIDTH_W'(1)) && stat.idx_zero;
            error_reg <= 1'b0;
        end else if (cmd.out_digit) begin
            char_reg  <= glyph(rd_data);
            last_reg  <= (idx_reg == CW'(1));
            error_reg <= 1'b0;
        end else if (cmd.out_err) begin
            char_reg  <= CHAR_NONE;
            last_reg  <= 1'b1;
            error_reg <= 1'b1;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_character = char_reg;
    assign m_last      = last_reg;
    assign m_error     = error_reg;

    `UTRD_ASSERT_SAME(a_store_in_range, aclk, aresetn, cmd.write_digit,
        count_reg < CW'(VALUE_WIDTH))
    `UTRD_ASSERT_SAME(a_digit_below_radix, aclk, aresetn, cmd.write_digit,
        rem_reg < radix_reg)
    `UTRD_ASSERT_SAME(a_err_only_bad_radix, aclk, aresetn, cmd.out_err, stat.radix_bad)
    `UTRD_ASSERT_SAME(a_no_overwrite, aclk, aresetn,
        cmd.out_pad || cmd.out_digit || cmd.out_err, stat.out_free)
    `UTRD_ASSERT_NEXT(a_digit_read_valid, aclk, aresetn, cmd.rd_issue,
        !stat.idx_zero || cmd.out_digit || !stat.out_free)

endmodule

@@ hdl/unsigned_to_radix_digits_unit.sv @@
// top level of the unsigned to radix ASCII conversion unit
//
//   channel | direction | ports                                     | request
//   s_      | in        | s_value, s_radix, s_min_width             | one number to convert
//   m_      | out       | m_character, m_last, m_error              | one ASCII character
//
// each digit is worked out in the bit-serial restoring divider, then written to the digit store,
// and all digits are worked out before the first character is output
// padding characters leave one a cycle while the output is not stalled; each digit waits for its store read
// the divider is the limit on conversion time
// a new request is taken once the last character sits in the output register
// reset is synchronous and active low; output stalls hold the sequencer
`timescale 1ns / 1ps

module unsigned_to_radix_digits_unit
    import utrd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_value,
    input  logic [RADIX_W-1:0]     s_radix,
    input  logic [WIDTH_W-1:0]     s_min_width,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [CHAR_W-1:0]      m_character,
    output logic                   m_last,
    output logic                   m_error
);

    utrd_cmd_t  cmd;
    utrd_stat_t stat;

    utrd_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    utrd_datapath #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .s_value    (s_value),
        .s_radix    (s_radix),
        .s_min_width(s_min_width),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_character(m_character),
        .m_last     (m_last),
        .m_error    (m_error)
    );

endmodule
